[design/text_terminal_scrollback_top_assert.svh]
// ----------------------------------------------------------------------------
// Text terminal scrollback - assertion macros
// Clocked, reset-qualified assertion wrappers for the terminal core.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCROLLBACK_TOP_ASSERT_SVH
`define TEXT_TERMINAL_SCROLLBACK_TOP_ASSERT_SVH

// invariant checked at every edge outside reset
`define TTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition at one edge implies expression at the next edge
`define TTS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

[design/tts_pkg.sv]
// ----------------------------------------------------------------------------
// Text terminal scrollback - package
// Sizes, character codes, commands and request/result types.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int RING_LINES = 1024;
    localparam int COLUMNS    = 61;
    localparam int VIEW_ROWS  = 34;

    localparam int LINE_W   = $clog2(RING_LINES);
    localparam int CNT_W    = LINE_W + 1;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int CODE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int DELTA_W  = 12;
    localparam int SUM_W    = ((LINE_W + 1 > DELTA_W) ? LINE_W + 1 : DELTA_W) + 1;
    localparam int CELLS    = RING_LINES * COLUMNS;
    localparam int ADDR_W   = $clog2(CELLS);

    localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CH_FIRST     = 8'd32;
    localparam logic [CODE_W-1:0] CH_LAST      = 8'd126;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 7'd32;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_WIPE   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic [CODE_W-1:0]          char_code;
        logic signed [DELTA_W-1:0]  scroll_delta;
        logic [ROW_W-1:0]           read_row;
        logic [COL_W-1:0]           read_col;
    } t_in_item;

    typedef struct packed {
        logic [LINE_W-1:0] cursor_line;
        logic [COL_W-1:0]  cursor_col;
        logic [CNT_W-1:0]  line_count;
        logic [LINE_W-1:0] view_line;
        logic              tail_on;
        logic [CHAR_W-1:0] read_char;
        logic              read_valid;
        logic              cursor_in_view;
    } t_out_item;

    typedef struct packed {
        logic             rd;
        logic             ok;
        logic             is_cur;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] cur_fill;
    } t_rd_info;

endpackage

`default_nettype wire

[design/text_terminal_scrollback_top.sv]
// ----------------------------------------------------------------------------
// Text terminal scrollback - top level
// Character terminal with a ring of history lines, scrolling view and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / i_in_data; o_in_stall holds the source.
//   Each request is put char, scroll view, clear all or read cell, and gives
//   exactly one result on o_out_valid / o_out_data, held by i_out_stall.
//   A result is valid once its request has passed the request register, the
//   text/fill memory read register and the result register.
//   Throughput: one request per cycle unless a result waits under i_out_stall;
//   the state update is registered as the next request enters and seen at once.
//   Line blanking needs no clearing pass: each line keeps a fill count of written
//   columns in a line-fill memory, and cells past it read as space.
//   Reset: synchronous, active low; cursor at line 0 column 0, one line in
//   use, view at top and following the tail. No clearing pass is needed.
//   o_in_stall is high while reset is held.
//   Stall: while a result waits under i_out_stall the whole pipeline holds
//   and o_in_stall is high; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_scrollback_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tts_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tts_pkg::t_out_item      o_out_data
);
    import tts_pkg::*;

    function automatic logic [LINE_W-1:0] phys(input logic [LINE_W-1:0] rb,
                                               input logic [LINE_W-1:0] ln);
        logic [LINE_W:0] s;
        s = {1'b0, rb} + {1'b0, ln};
        if (s >= (LINE_W + 1)'(RING_LINES)) begin
            s = s - (LINE_W + 1)'(RING_LINES);
        end
        return s[LINE_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] pl,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(pl) * ADDR_W'(COLUMNS) + ADDR_W'(c));
    endfunction

    function automatic logic [LINE_W-1:0] bottom_of(input logic [CNT_W-1:0] used);
        logic [CNT_W-1:0] d;
        d = used - CNT_W'(VIEW_ROWS);
        return (used <= CNT_W'(VIEW_ROWS)) ? '0 : d[LINE_W-1:0];
    endfunction

    logic en;

    logic        r_in_valid;
    t_in_item    r_in;

    logic [LINE_W-1:0] r_ring, n_ring;
    logic [LINE_W-1:0] r_line, n_line;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [LINE_W-1:0] r_view, n_view;
    logic              r_follow, n_follow;
    logic [COL_W-1:0]  r_fill, n_fill;

    logic              nl_wrap;
    logic [LINE_W-1:0] nl_ring, nl_line, nl_view;
    logic [CNT_W-1:0]  nl_used;

    logic [CODE_W-1:0] code;
    logic              printable;
    logic [LINE_W-1:0] cur_phys;
    logic [COL_W-1:0]  wr_col;
    logic [LINE_W-1:0] scr_bot;
    logic signed [SUM_W-1:0] s_top, s_bot;

    logic              txt_we;
    logic [ADDR_W-1:0] txt_waddr;
    logic [CHAR_W-1:0] txt_wdata;
    logic              fill_we;

    logic [CNT_W-1:0]  rd_logical;
    logic [LINE_W-1:0] rd_phys;
    logic [ADDR_W-1:0] txt_raddr;
    t_rd_info          rd_info;

    t_out_item         s2_item;

    logic [CHAR_W-1:0] txt_mem [CELLS];
    logic [COL_W-1:0]  fill_mem [RING_LINES];
    logic [CHAR_W-1:0] r_txt_q;
    logic [COL_W-1:0]  r_fill_q;

    logic        r_s2_valid;
    t_out_item   r_s2;
    t_rd_info    r_rd;

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   out_item;
    logic        in_fill;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_in_valid;
        end
        if (en && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // new-line candidate state
    always_comb begin
        nl_wrap = (r_line == LINE_W'(RING_LINES - 1));
        nl_ring = r_ring;
        nl_line = r_line + LINE_W'(1);
        nl_view = r_view;
        if (nl_wrap) begin
            nl_ring = (r_ring == LINE_W'(RING_LINES - 1)) ? '0 : r_ring + LINE_W'(1);
            nl_line = r_line;
            if (r_view != '0) begin
                nl_view = r_view - LINE_W'(1);
            end
        end
        nl_used = (CNT_W'(nl_line) + CNT_W'(1) > r_used) ?
                  CNT_W'(nl_line) + CNT_W'(1) : r_used;
    end

    // next state and memory writes
    always_comb begin
        n_ring    = r_ring;
        n_line    = r_line;
        n_col     = r_col;
        n_used    = r_used;
        n_view    = r_view;
        n_follow  = r_follow;
        n_fill    = r_fill;
        txt_we    = 1'b0;
        txt_waddr = '0;
        txt_wdata = CH_BLANK;
        fill_we   = 1'b0;
        wr_col    = '0;
        s_top     = '0;
        s_bot     = '0;
        code      = r_in.char_code;
        printable = (code >= CH_FIRST) && (code <= CH_LAST);
        cur_phys  = phys(r_ring, r_line);
        scr_bot   = bottom_of(r_used);
        if (r_in_valid) begin
            unique case (r_in.cmd)
                CMD_PUT: begin
                    if (code == CH_NEWLINE || (printable && r_col >= COL_W'(COLUMNS))) begin
                        n_ring  = nl_ring;
                        n_line  = nl_line;
                        n_view  = nl_view;
                        n_used  = nl_used;
                        n_col   = '0;
                        n_fill  = '0;
                        fill_we = 1'b1;
                    end
                    if (code == CH_BACKSPACE && r_col != '0) begin
                        n_col     = r_col - COL_W'(1);
                        txt_we    = 1'b1;
                        txt_waddr = cell_addr(cur_phys, n_col);
                        txt_wdata = CH_BLANK;
                    end
                    if (printable) begin
                        wr_col    = n_col;
                        txt_we    = 1'b1;
                        txt_waddr = cell_addr(phys(n_ring, n_line), wr_col);
                        txt_wdata = code[CHAR_W-1:0];
                        n_col     = wr_col + COL_W'(1);
                        if (n_col > n_fill) begin
                            n_fill = n_col;
                        end
                    end
                    if ((code == CH_NEWLINE || printable) && r_follow) begin
                        n_view = bottom_of(n_used);
                    end
                end
                CMD_SCROLL: begin
                    s_top = $signed(SUM_W'(r_view)) + SUM_W'($signed(r_in.scroll_delta));
                    s_bot = $signed(SUM_W'(scr_bot));
                    priority if (s_top < 0) begin
                        n_view = '0;
                    end else if (s_top > s_bot) begin
                        n_view = scr_bot;
                    end else begin
                        n_view = s_top[LINE_W-1:0];
                    end
                    n_follow = (n_view == scr_bot);
                end
                CMD_WIPE: begin
                    n_ring   = '0;
                    n_line   = '0;
                    n_col    = '0;
                    n_used   = CNT_W'(1);
                    n_view   = '0;
                    n_follow = 1'b1;
                    n_fill   = '0;
                end
                CMD_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    // read-cell lookup
    always_comb begin
        rd_logical      = CNT_W'(r_view) + CNT_W'(r_in.read_row);
        rd_phys         = phys(r_ring, rd_logical[LINE_W-1:0]);
        txt_raddr       = cell_addr(rd_phys, r_in.read_col);
        rd_info.rd      = r_in_valid && (r_in.cmd == CMD_READ);
        rd_info.ok      = (r_in.read_row < ROW_W'(VIEW_ROWS)) && (rd_logical < r_used)
                          && (r_in.read_col < COL_W'(COLUMNS));
        rd_info.is_cur  = (rd_logical[LINE_W-1:0] == r_line);
        rd_info.col     = r_in.read_col;
        rd_info.cur_fill = r_fill;
    end

    always_comb begin
        s2_item.cursor_line    = n_line;
        s2_item.cursor_col     = n_col;
        s2_item.line_count     = n_used;
        s2_item.view_line      = n_view;
        s2_item.tail_on        = n_follow;
        s2_item.read_char      = '0;
        s2_item.read_valid     = 1'b0;
        s2_item.cursor_in_view = (n_line >= n_view)
                                 && (CNT_W'(n_line) < CNT_W'(n_view) + CNT_W'(VIEW_ROWS));
    end

    // terminal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring   <= '0;
            r_line   <= '0;
            r_col    <= '0;
            r_used   <= CNT_W'(1);
            r_view   <= '0;
            r_follow <= 1'b1;
            r_fill   <= '0;
        end else if (en) begin
            r_ring   <= n_ring;
            r_line   <= n_line;
            r_col    <= n_col;
            r_used   <= n_used;
            r_view   <= n_view;
            r_follow <= n_follow;
            r_fill   <= n_fill;
        end
    end

    // text store
    always_ff @(posedge i_clk) begin
        if (en && txt_we) begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        if (en && rd_info.rd && rd_info.ok) begin
            r_txt_q <= txt_mem[txt_raddr];
        end
    end

    // line fill counts
    always_ff @(posedge i_clk) begin
        if (en && fill_we) begin
            fill_mem[cur_phys] <= r_fill;
        end
        if (en) begin
            r_fill_q <= fill_mem[rd_phys];
        end
    end

    // memory read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_in_valid;
        end
        if (en) begin
            r_s2 <= s2_item;
            r_rd <= rd_info;
        end
    end

    always_comb begin
        in_fill  = r_rd.is_cur ? (r_rd.col < r_rd.cur_fill) : (r_rd.col < r_fill_q);
        out_item = r_s2;
        out_item.read_valid = r_rd.rd && r_rd.ok;
        if (!r_rd.rd) begin
            out_item.read_char = '0;
        end else if (r_rd.ok && in_fill) begin
            out_item.read_char = r_txt_q;
        end else begin
            out_item.read_char = CH_BLANK;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
        if (en) begin
            r_out <= out_item;
        end
    end

`include "text_terminal_scrollback_top_assert.svh"

    `TTS_ASSERT(a_used_line, r_used == CNT_W'(r_line) + CNT_W'(1), "lines in use off cursor")
    `TTS_ASSERT(a_col_fill, (r_col <= r_fill) && (r_fill <= COL_W'(COLUMNS)), "column past fill")
    `TTS_ASSERT(a_tail_bottom, !r_follow || (r_view == bottom_of(r_used)), "tail off bottom")
    `TTS_ASSERT_NEXT(a_stall_hold, !en, $stable({r_line, r_col, r_view, r_in_valid}), "stall moved")
    `TTS_ASSERT_NEXT(a_read_hold, en && rd_info.rd, $stable({r_line, r_used, r_view}), "read moved")

endmodule

`default_nettype wire

[sim/text_terminal_scrollback_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text terminal scrollback - testbench
// Drives put, scroll, clear and read requests with bursty input and a random
// output stall pattern. Each result is checked field by field against an
// in-bench terminal predictor: directed edge cases, line wrap, a random mix,
// and a long newline run that fills the history ring and rolls it over.
// ----------------------------------------------------------------------------
module text_terminal_scrollback_top_test;
    import tts_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LIMIT  = 10;
    localparam int MIX_ITEMS     = 260;
    localparam int ROLL_EXTRA    = 150;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    text_terminal_scrollback_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // terminal predictor state
    logic [CHAR_W-1:0] hist_cells [CELLS];
    int unsigned       ring_head;
    int unsigned       pos_line;
    int unsigned       cur_col;
    int unsigned       used_lines;
    int unsigned       view_first;
    bit                tail_track;
    t_out_item         pending_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int gap_max        = 0;
    int burst_left     = 0;
    int stall_pct      = 0;
    int stall_run      = 0;

    function automatic int unsigned cell_addr(int unsigned logical, int unsigned col);
        int unsigned phys;
        phys = (ring_head + logical % RING_LINES) % RING_LINES;
        return phys * COLUMNS + col;
    endfunction

    function automatic int unsigned bottom_line();
        return (used_lines <= VIEW_ROWS) ? 0 : used_lines - VIEW_ROWS;
    endfunction

    function automatic void terminal_reset();
        foreach (hist_cells[i]) hist_cells[i] = CH_BLANK;
        ring_head  = 0;
        pos_line   = 0;
        cur_col    = 0;
        used_lines = 1;
        view_first = 0;
        tail_track = 1'b1;
    endfunction

    function automatic void open_line();
        cur_col = 0;
        if (pos_line + 1 >= RING_LINES) begin
            // drop the oldest line, reuse its slot
            ring_head = (ring_head + 1) % RING_LINES;
            pos_line  = RING_LINES - 1;
            if (view_first > 0) view_first--;
        end else begin
            pos_line++;
        end
        if (pos_line + 1 > used_lines) used_lines = pos_line + 1;
        for (int c = 0; c < COLUMNS; c++) hist_cells[cell_addr(pos_line, c)] = CH_BLANK;
        if (tail_track) view_first = bottom_line();
    endfunction

    function automatic t_out_item terminal_predict(t_in_item req);
        t_out_item   res;
        int          top;
        int          bottom;
        int unsigned logical;
        res = '0;
        case (req.cmd)
            CMD_PUT: begin
                if (req.char_code == CH_NEWLINE) begin
                    open_line();
                end else if (req.char_code == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        hist_cells[cell_addr(pos_line, cur_col)] = CH_BLANK;
                    end
                end else if (req.char_code >= CH_FIRST && req.char_code <= CH_LAST) begin
                    if (cur_col >= COLUMNS) open_line();
                    hist_cells[cell_addr(pos_line, cur_col)] = req.char_code[CHAR_W-1:0];
                    cur_col++;
                    if (tail_track) view_first = bottom_line();
                end
            end
            CMD_SCROLL: begin
                bottom = int'(bottom_line());
                top    = int'(view_first) + int'($signed(req.scroll_delta));
                if (top < 0) top = 0;
                if (top > bottom) top = bottom;
                view_first = unsigned'(top);
                tail_track = (top == bottom);
            end
            CMD_WIPE: begin
                terminal_reset();
            end
            default: begin
                logical = view_first + req.read_row;
                if (req.read_row < VIEW_ROWS && logical < used_lines &&
                    req.read_col < COLUMNS) begin
                    res.read_valid = 1'b1;
                    res.read_char  = hist_cells[cell_addr(logical, req.read_col)];
                end else begin
                    res.read_char = CH_BLANK;
                end
            end
        endcase
        res.cursor_line    = pos_line[LINE_W-1:0];
        res.cursor_col     = cur_col[COL_W-1:0];
        res.line_count     = used_lines[CNT_W-1:0];
        res.view_line      = view_first[LINE_W-1:0];
        res.tail_on        = tail_track;
        res.cursor_in_view = (pos_line >= view_first && pos_line < view_first + VIEW_ROWS);
        return res;
    endfunction

    function automatic t_in_item rand_request(t_cmd c);
        t_in_item r;
        r.cmd          = c;
        r.char_code    = CODE_W'($urandom_range(0, 255));
        r.scroll_delta = DELTA_W'(int'($urandom_range(0, 2048)) - 1024);
        r.read_row     = ROW_W'($urandom_range(0, 63));
        r.read_col     = COL_W'($urandom_range(0, 63));
        return r;
    endfunction

    function automatic t_in_item rand_put();
        t_in_item r;
        int       pick;
        r    = rand_request(CMD_PUT);
        pick = $urandom_range(0, 99);
        if (pick < 65)      r.char_code = CODE_W'($urandom_range(CH_FIRST, CH_LAST));
        else if (pick < 80) r.char_code = CH_NEWLINE;
        else if (pick < 90) r.char_code = CH_BACKSPACE;
        return r;
    endfunction

    function automatic t_in_item rand_scroll();
        t_in_item r;
        r = rand_request(CMD_SCROLL);
        if ($urandom_range(0, 1)) r.scroll_delta = DELTA_W'(int'($urandom_range(0, 24)) - 12);
        return r;
    endfunction

    function automatic t_in_item rand_read();
        t_in_item r;
        r = rand_request(CMD_READ);
        r.read_row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(VIEW_ROWS, 63))
                                                 : ROW_W'($urandom_range(0, VIEW_ROWS - 1));
        r.read_col = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(COLUMNS, 63))
                                                 : COL_W'($urandom_range(0, COLUMNS - 1));
        return r;
    endfunction

    task automatic send_request(input t_in_item req);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max > 0) begin
                repeat ($urandom_range(0, gap_max)) begin
                    @(negedge i_clk);
                    in_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(terminal_predict(req));
    endtask

    task automatic send_put(input logic [CODE_W-1:0] code);
        t_in_item r;
        r = rand_request(CMD_PUT);
        r.char_code = code;
        send_request(r);
    endtask

    task automatic send_scroll(input int delta);
        t_in_item r;
        r = rand_request(CMD_SCROLL);
        r.scroll_delta = DELTA_W'(delta);
        send_request(r);
    endtask

    task automatic send_read(input int row, input int col);
        t_in_item r;
        r = rand_request(CMD_READ);
        r.read_row = ROW_W'(row);
        r.read_col = COL_W'(col);
        send_request(r);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        gap_max   = 2;
        stall_pct = 20;
        send_read(0, 0);
        send_read(VIEW_ROWS, 0);
        send_read(63, 5);
        send_read(0, COLUMNS);
        send_read(0, 63);
        send_read(1, 0);
        send_put(CH_BACKSPACE);
        send_put(8'd0);
        send_put(8'd31);
        send_put(8'd127);
        send_put(8'd255);
        send_put(CH_FIRST);
        send_put(CH_LAST);
        send_put(8'd65);
        send_put(CH_BACKSPACE);
        send_put(CH_NEWLINE);
        send_scroll(-1024);
        send_scroll(1024);
        send_scroll(0);
        send_scroll(-1);
        send_read(0, 0);
        send_read(0, 1);
        send_request(rand_request(CMD_WIPE));
        send_read(0, 0);
        drain_results();
    endtask

    task automatic test_line_wrap();
        gap_max   = 0;
        stall_pct = 0;
        repeat (COLUMNS) send_put(CODE_W'($urandom_range(CH_FIRST, CH_LAST)));
        send_read(0, COLUMNS - 1);
        // backspace while wrap is pending
        send_put(CH_BACKSPACE);
        send_read(0, COLUMNS - 1);
        send_put(CODE_W'($urandom_range(CH_FIRST, CH_LAST)));
        gap_max   = 4;
        stall_pct = 40;
        repeat (COLUMNS + 1) send_put(CODE_W'($urandom_range(CH_FIRST, CH_LAST)));
        send_read(1, 0);
        send_read(0, COLUMNS - 1);
        drain_results();
    endtask

    task automatic test_random_mix();
        int pick;
        for (int n = 0; n < MIX_ITEMS; n++) begin
            if (n % 52 == 0) begin
                gap_max   = (n == 0) ? 0 : $urandom_range(0, 8);
                stall_pct = (n == 0) ? 0 : $urandom_range(0, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)      send_request(rand_put());
            else if (pick < 70) send_request(rand_scroll());
            else if (pick < 97) send_request(rand_read());
            else                send_request(rand_request(CMD_WIPE));
        end
        drain_results();
    endtask

    task automatic test_history_rollover();
        t_in_item r;
        int       pick;
        int       extra;
        extra     = 0;
        gap_max   = 3;
        stall_pct = 25;
        send_request(rand_request(CMD_WIPE));
        while (extra < ROLL_EXTRA) begin
            pick = $urandom_range(0, 99);
            if (used_lines == RING_LINES) begin
                extra++;
                if (pick < 40) begin
                    r = rand_request(CMD_PUT);
                    r.char_code = CH_NEWLINE;
                    send_request(r);
                end else if (pick < 65) send_request(rand_put());
                else if (pick < 80)     send_request(rand_scroll());
                else                    send_request(rand_read());
            end else begin
                if (pick < 85) begin
                    r = rand_request(CMD_PUT);
                    r.char_code = CH_NEWLINE;
                    send_request(r);
                end else if (pick < 90) send_request(rand_put());
                else if (pick < 95)     send_request(rand_scroll());
                else                    send_request(rand_read());
            end
        end
        drain_results();
    endtask

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, 8);
        end else begin
            stall_run--;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with no request waiting: line %0d col %0d",
                             $time, out_data.cursor_line, out_data.cursor_col);
            end else begin
                want = pending_results.pop_front();
                if (out_data.cursor_line    !== want.cursor_line    ||
                    out_data.cursor_col     !== want.cursor_col     ||
                    out_data.line_count     !== want.line_count     ||
                    out_data.view_line      !== want.view_line      ||
                    out_data.tail_on        !== want.tail_on        ||
                    out_data.read_char      !== want.read_char      ||
                    out_data.read_valid     !== want.read_valid     ||
                    out_data.cursor_in_view !== want.cursor_in_view) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch exp/act line %0d/%0d col %0d/%0d ",
                                  "count %0d/%0d top %0d/%0d follow %0b/%0b ",
                                  "char %0d/%0d rvalid %0b/%0b inview %0b/%0b"},
                                 $time, want.cursor_line, out_data.cursor_line,
                                 want.cursor_col, out_data.cursor_col,
                                 want.line_count, out_data.line_count,
                                 want.view_line, out_data.view_line,
                                 want.tail_on, out_data.tail_on,
                                 want.read_char, out_data.read_char,
                                 want.read_valid, out_data.read_valid,
                                 want.cursor_in_view, out_data.cursor_in_view);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        terminal_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_line_wrap();
        test_random_mix();
        test_history_rollover();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/tts_pkg.sv
design/text_terminal_scrollback_top.sv
sim/text_terminal_scrollback_top_test.sv
